// ===== hw/rtl/cbip_pkg.sv =====
package cbip_pkg;

  localparam int unsigned MaxAlphabetDef = 16;
  localparam int unsigned AlphaCharsMax = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned LenW = 5;
  localparam int unsigned DigitW = 4;

  localparam logic [ByteW-1:0] ChNul = 8'd0;
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChTab = 8'd9;
  localparam logic [ByteW-1:0] ChCr = 8'd13;
  localparam logic [ByteW-1:0] ChPlus = 8'd43;
  localparam logic [ByteW-1:0] ChMinus = 8'd45;

  localparam logic [CfgIdxW-1:0] CfgAlphaLow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlphaHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAlphaLen = 2'd2;

  typedef enum logic [1:0] {
    PhSpace,
    PhSign,
    PhDigit,
    PhDone
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
  } text_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     alphabet_ok;
  } result_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

// ===== hw/rtl/cbip_stream_if.sv =====
interface cbip_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/custom_base_integer_parser.sv =====
// Integer parser over a configurable digit alphabet.
// Text arrives one byte per request on text_in_i, a NUL byte ending each
// string. Leading whitespace is skipped, a run of signs is read, then digits
// of the configured alphabet are gathered as acc * length + digit, wrapping
// at 32 bits. One request leaves on result_out_o per string, carrying the
// signed value and the alphabet check flag, at the first byte that is not
// part of the number; bytes after it are dropped up to the NUL.
// The alphabet is written through cfg_we_i / cfg_idx_i / cfg_data_i; the
// user must write it only while no string is in flight, which the block
// itself does not enforce. It is checked afresh for every byte. Throughput
// is one byte per cycle while no result waits on a stalled receiver.
// A byte sits in the input register for the alphabet match and the 32 by
// 5 bit multiply-add; its result is then registered. When the receiver
// stalls, the result register holds its request; bytes that give no result
// keep flowing, and a byte that would give a result waits in the input
// register, which then stops further bytes. Reset empties both registers,
// clears the alphabet and returns the parser to skipping whitespace.
module custom_base_integer_parser
  import cbip_pkg::*;
#(
  parameter int unsigned MaxAlphabet = MaxAlphabetDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cbip_stream_if.sink         text_in_i,
  cbip_stream_if.source       result_out_o
);

  logic [CfgDataW-1:0] alpha_low_q, alpha_high_q;
  logic [LenW-1:0]     alpha_len_q;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;

  phase_e              phase_q, phase_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  logic                neg_q, neg_d;

  logic                out_valid_q;
  logic [ValueW-1:0]   out_value_q;
  logic                out_ok_q;

  logic [2*CfgDataW-1:0] alpha_bits;
  logic                  alpha_ok;
  logic                  digit_hit;
  logic [DigitW-1:0]     digit_val;
  logic [ValueW-1:0]     acc_mul;

  logic c_ws, c_sign, c_nul;
  logic ev_restart, ev_sign, ev_digit, ev_result;
  logic out_free, advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= '0;
      alpha_high_q <= '0;
      alpha_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAlphaLow:  alpha_low_q  <= cfg_data_i;
        CfgAlphaHigh: alpha_high_q <= cfg_data_i;
        CfgAlphaLen:  alpha_len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_bits = {alpha_high_q, alpha_low_q};

  // Alphabet check: length, banned characters, every pair in use compared.
  always_comb begin
    alpha_ok = (alpha_len_q >= LenW'(2)) && (alpha_len_q <= LenW'(MaxAlphabet));
    for (int i = 0; i < MaxAlphabet; i++) begin
      if (LenW'(i) < alpha_len_q) begin
        if ((alpha_bits[ByteW*i +: ByteW] == ChNul) ||
            is_ws(alpha_bits[ByteW*i +: ByteW]) ||
            (alpha_bits[ByteW*i +: ByteW] == ChPlus) ||
            (alpha_bits[ByteW*i +: ByteW] == ChMinus)) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MaxAlphabet; j++) begin
          if ((LenW'(j) < alpha_len_q) &&
              (alpha_bits[ByteW*j +: ByteW] == alpha_bits[ByteW*i +: ByteW])) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Digit lookup; the lowest matching position wins.
  always_comb begin
    digit_hit = 1'b0;
    digit_val = '0;
    for (int i = MaxAlphabet - 1; i >= 0; i--) begin
      if ((LenW'(i) < alpha_len_q) && (alpha_bits[ByteW*i +: ByteW] == in_byte_q)) begin
        digit_hit = alpha_ok;
        digit_val = DigitW'(i);
      end
    end
  end

  assign acc_mul = ValueW'(acc_q * ValueW'(alpha_len_q));

  assign c_ws   = is_ws(in_byte_q);
  assign c_sign = (in_byte_q == ChPlus) || (in_byte_q == ChMinus);
  assign c_nul  = (in_byte_q == ChNul);

  always_comb begin
    ev_restart = 1'b0;
    ev_sign    = 1'b0;
    ev_digit   = 1'b0;
    ev_result  = 1'b0;
    if (phase_q == PhDone) begin
      ev_restart = c_nul;
    end else if ((phase_q == PhSpace) && c_ws) begin
      // Leading whitespace passes without touching the parser state.
    end else if ((phase_q != PhDigit) && c_sign) begin
      ev_sign = 1'b1;
    end else if (digit_hit) begin
      ev_digit = 1'b1;
    end else begin
      ev_result = 1'b1;
    end
  end

  assign out_free = !out_valid_q || result_out_o.ready;
  assign advance  = in_valid_q && (!ev_result || out_free);
  assign text_in_i.ready = !in_valid_q || advance;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (ev_restart) begin
      phase_d = PhSpace;
    end else if (ev_sign) begin
      phase_d = PhSign;
    end else if (ev_digit) begin
      phase_d = PhDigit;
    end else if (ev_result) begin
      phase_d = c_nul ? PhSpace : PhDone;
    end
  end

  // Accumulator and sign.
  always_comb begin
    acc_d = acc_q;
    neg_d = neg_q;
    if (ev_restart || ev_result) begin
      acc_d = '0;
      neg_d = 1'b0;
    end else if (ev_sign) begin
      neg_d = neg_q ^ (in_byte_q == ChMinus);
    end else if (ev_digit) begin
      acc_d = acc_mul + ValueW'(digit_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_in_i.ready) begin
      in_valid_q <= text_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_in_i.ready && text_in_i.valid) begin
      in_byte_q <= text_in_i.payload.text_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSpace;
      acc_q   <= '0;
      neg_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && ev_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && ev_result) begin
      out_value_q <= !alpha_ok ? '0 : (neg_q ? (ValueW'(0) - acc_q) : acc_q);
      out_ok_q    <= alpha_ok;
    end
  end

  assign result_out_o.valid               = out_valid_q;
  assign result_out_o.payload.value       = out_value_q;
  assign result_out_o.payload.alphabet_ok = out_ok_q;

endmodule

// ===== test/tb_custom_base_integer_parser.sv =====
`timescale 1ns / 100ps

module tb_custom_base_integer_parser;
  import cbip_pkg::*;

  localparam logic [63:0] HexLow = 64'h3736_3534_3332_3130;
  // Digits 8, 9, a to e, with 8'hff standing in as digit fifteen.
  localparam logic [63:0] HexHigh = 64'hff65_6463_6261_3938;

  typedef struct packed {
    logic [7:0] b;
    logic       calm;
    logic       pinned;
    result_t    pin;
  } feed_t;

  typedef struct packed {
    logic                set_alpha;
    logic                open;
    logic [63:0]         lo;
    logic [63:0]         hi;
    logic [4:0]          len;
    logic [95:0]         txt;
    logic [3:0]          n;
    logic                pinned;
    logic signed [31:0]  pin_value;
    logic                pin_ok;
  } drow_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cbip_stream_if #(.payload_t(text_t))   text_if ();
  cbip_stream_if #(.payload_t(result_t)) res_if ();

  custom_base_integer_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .text_in_i   (text_if),
    .result_out_o(res_if)
  );

  // Predictor state and its copy of the alphabet registers.
  logic [63:0] alpha_lo = '0;
  logic [63:0] alpha_hi = '0;
  logic [4:0]  alpha_len = '0;
  phase_e      parse_ph = PhSpace;
  logic [31:0] acc = '0;
  logic        neg = 1'b0;

  result_t     pending_results[$];
  feed_t       text_feed[$];
  feed_t       on_offer;
  logic        offering = 1'b0;
  logic        calm_now = 1'b0;
  int          hold_request = 0;
  int          error_count = 0;

  logic        cur_calm = 1'b0;
  logic        cur_pin_on = 1'b0;
  result_t     cur_pin = '0;
  logic [7:0]  digit_set [16];
  int          digit_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("custom_base_integer_parser verification failed");
    $finish;
  end

  function automatic logic blank(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic [7:0] alpha_at(input int i);
    if (i < 8) begin
      return alpha_lo[8*i +: 8];
    end
    return alpha_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic alphabet_sound();
    int n;
    logic [7:0] c;
    n = alpha_len;
    if (n < 2 || n > MaxAlphabetDef) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = alpha_at(i);
      if (c == ChNul || blank(c) || c == ChPlus || c == ChMinus) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (alpha_at(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte closes a number.
  function automatic logic parse_step(input logic [7:0] c, output result_t r);
    logic ok;
    int   d;
    ok = alphabet_sound();
    d = -1;
    r = '0;
    if (ok) begin
      for (int i = 0; i < alpha_len; i++) begin
        if (d < 0 && alpha_at(i) == c) d = i;
      end
    end
    if (parse_ph == PhDone) begin
      if (c == ChNul) begin
        parse_ph = PhSpace;
        acc = '0;
        neg = 1'b0;
      end
      return 1'b0;
    end
    if (parse_ph == PhSpace && blank(c)) return 1'b0;
    if (parse_ph != PhDigit && (c == ChPlus || c == ChMinus)) begin
      if (c == ChMinus) neg = ~neg;
      parse_ph = PhSign;
      return 1'b0;
    end
    if (d >= 0) begin
      acc = acc * 32'(alpha_len) + 32'(d);
      parse_ph = PhDigit;
      return 1'b0;
    end
    r.value = !ok ? 32'sd0 : (neg ? -acc : acc);
    r.alphabet_ok = ok;
    acc = '0;
    neg = 1'b0;
    parse_ph = (c == ChNul) ? PhSpace : PhDone;
    return 1'b1;
  endfunction

  function automatic logic listed(input logic [7:0] c, input int upto);
    for (int i = 0; i < upto; i++) begin
      if (digit_set[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    feed_t f;
    f.b = b;
    f.calm = cur_calm;
    f.pinned = cur_pin_on;
    f.pin = cur_pin;
    text_feed.push_back(f);
  endtask

  // Waits until the feed is empty and every result is back, then lets the
  // input register empty out before the alphabet may change.
  task automatic settle();
    while (text_feed.size() != 0 || offering || pending_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] lw);
    logic [63:0]        word [3];
    logic [CfgIdxW-1:0] idx [3];
    word = '{lo, hi, lw};
    idx = '{CfgAlphaLow, CfgAlphaHigh, CfgAlphaLen};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[k];
      cfg_data_i <= word[k];
      @(posedge clk_i);
      case (idx[k])
        CfgAlphaLow: alpha_lo = word[k];
        CfgAlphaHigh: alpha_hi = word[k];
        default: alpha_len = word[k][4:0];
      endcase
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly well-formed strings with random content; the odd one is noise or
  // has a blank between the signs and the digits.
  task automatic queue_random_string(inout int tally);
    int         n;
    int         span;
    logic [7:0] c;
    span = (digit_count < 1) ? 1 : digit_count;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) queue_byte(8'($urandom_range(0, 255)));
      tally += n;
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) begin
        c = ($urandom_range(0, 5) == 0) ? ChSpace : 8'($urandom_range(9, 13));
        queue_byte(c);
      end
      tally += n;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) queue_byte($urandom_range(0, 1) ? ChPlus : ChMinus);
      tally += n;
      if ($urandom_range(0, 15) == 0) begin
        queue_byte(ChSpace);
        tally++;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      repeat (n) queue_byte(digit_set[$urandom_range(0, span - 1)]);
      tally += n;
      if ($urandom_range(0, 2) != 0) begin
        do c = 8'($urandom_range(1, 255)); while (listed(c, span));
        queue_byte(c);
        tally++;
        // Bytes after the result are dropped up to the NUL.
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(1, 255)));
      end
    end
    queue_byte(ChNul);
    tally++;
  endtask

  // Text sender: one request in flight, idling in random bursts.
  initial begin
    int gap_left;
    gap_left = 0;
    text_if.valid = 1'b0;
    text_if.payload = '0;
    forever begin
      @(posedge clk_i);
      if (text_if.valid && text_if.ready) offering = 1'b0;
      @(negedge clk_i);
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
          text_if.valid <= 1'b0;
        end else if (text_feed.size() != 0) begin
          if (!text_feed[0].calm && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 8);
            text_if.valid <= 1'b0;
          end else begin
            on_offer = text_feed.pop_front();
            calm_now = on_offer.calm;
            text_if.payload <= '{text_byte: on_offer.b};
            text_if.valid <= 1'b1;
            offering = 1'b1;
          end
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when asked for.
  initial begin
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request - 1;
        hold_request = 0;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!calm_now && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 8);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t predicted;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) begin
        if (parse_step(text_if.payload.text_byte, predicted))
          pending_results.push_back(on_offer.pinned ? on_offer.pin : predicted);
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d with nothing pending", got.value));
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value)
            flag_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
          if (got.alphabet_ok !== want.alphabet_ok)
            flag_mismatch($sformatf("alphabet_ok %0b, expected %0b",
                                    got.alphabet_ok, want.alphabet_ok));
        end
      end
    end
  end

  initial begin
    drow_t       plan [10];
    int          tally;
    int          phase_no;
    int          phase_goal;
    int          len;
    int          j;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lw;
    logic [7:0]  c;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgAlphaLow;
    cfg_data_i = '0;
    for (int i = 0; i < 16; i++) digit_set[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // set_alpha, open, lo, hi, len, text, text length, pinned, value, ok
    plan = '{
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, "7", 4'd1, 1'b1, 32'sd0, 1'b0},
      '{1'b1, 1'b0, HexLow, HexHigh, 5'd16, 96'd0, 4'd0, 1'b0, 32'sd0, 1'b0},
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, "\015+-\377\200", 4'd5, 1'b1, -32'sd15, 1'b1},
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, "-80000000", 4'd9, 1'b1, 32'h8000_0000, 1'b1},
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, 96'd0, 4'd0, 1'b1, 32'sd0, 1'b1},
      '{1'b0, 1'b1, 64'd0, 64'd0, 5'd0, "-1", 4'd2, 1'b0, 32'sd0, 1'b0},
      '{1'b1, 1'b0, HexLow, HexHigh, 5'd10, 96'd0, 4'd0, 1'b0, 32'sd0, 1'b0},
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, "5a", 4'd2, 1'b0, 32'sd0, 1'b0},
      '{1'b1, 1'b0, HexLow, HexHigh, 5'd31, 96'd0, 4'd0, 1'b0, 32'sd0, 1'b0},
      '{1'b0, 1'b0, 64'd0, 64'd0, 5'd0, " -5", 4'd3, 1'b1, 32'sd0, 1'b0}
    };

    // Directed strings. An open row leaves its string unfinished, so the
    // alphabet change that follows lands in the middle of a number.
    foreach (plan[r]) begin
      if (plan[r].set_alpha) begin
        settle();
        write_alphabet(plan[r].lo, plan[r].hi, {59'd0, plan[r].len});
      end else begin
        cur_pin_on = plan[r].pinned;
        cur_pin = '{value: plan[r].pin_value, alphabet_ok: plan[r].pin_ok};
        for (int k = 0; k < plan[r].n; k++)
          queue_byte(plan[r].txt[8*(plan[r].n - 1 - k) +: 8]);
        if (!plan[r].open) queue_byte(ChNul);
        cur_pin_on = 1'b0;
      end
    end

    tally = 0;
    phase_no = 0;
    while (tally < 650) begin
      settle();
      phase_no++;
      if (phase_no == 2) begin
        // Every register bit set: sixteen copies of one character.
        for (int i = 0; i < 16; i++) digit_set[i] = 8'hff;
        len = 16;
      end else begin
        for (int i = 0; i < 16; i++) begin
          do c = 8'($urandom_range(1, 255));
          while (c == ChPlus || c == ChMinus || blank(c) || listed(c, i));
          digit_set[i] = c;
        end
        if (phase_no == 3) len = 2;
        else len = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(2, 16);
        if (phase_no != 4 && $urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 5))
            0: begin
              j = $urandom_range(1, len - 1);
              digit_set[j] = digit_set[$urandom_range(0, j - 1)];
            end
            1: digit_set[$urandom_range(0, len - 1)] =
                 ($urandom_range(0, 1) == 0) ? ChSpace : 8'($urandom_range(9, 13));
            2: digit_set[$urandom_range(0, len - 1)] = ChPlus;
            3: digit_set[$urandom_range(0, len - 1)] = ChMinus;
            4: digit_set[$urandom_range(0, len - 1)] = ChNul;
            default: len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                       : $urandom_range(17, 31);
          endcase
        end
        // Characters beyond the length in use must not matter.
        for (int i = len; i < 16; i++) begin
          if ($urandom_range(0, 1) == 0) digit_set[i] = 8'($urandom_range(0, 255));
        end
      end
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = digit_set[i];
        hi[8*i +: 8] = digit_set[i + 8];
      end
      lw = {$urandom(), $urandom()};
      lw[4:0] = len[4:0];
      write_alphabet(lo, hi, lw);
      digit_count = (len > 16) ? 16 : len;

      if (phase_no == 4) begin
        // The receiver holds off while strings keep coming, so a finished
        // result blocks the next one and the input stalls.
        hold_request = 150;
        repeat (12) queue_random_string(tally);
      end else begin
        phase_goal = tally + $urandom_range(40, 80);
        while (tally < phase_goal && tally < 650) begin
          cur_calm = (tally >= 570);
          queue_random_string(tally);
        end
      end
    end
    settle();

    if (error_count == 0) begin
      $display("custom_base_integer_parser verification clean");
    end else begin
      $display("custom_base_integer_parser verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/cbip_pkg.sv
hw/rtl/cbip_stream_if.sv
hw/rtl/custom_base_integer_parser.sv
test/tb_custom_base_integer_parser.sv
